/* design/tklt_pkg.sv */
// ----------------------------------------------------------------------------
// tklt_pkg
// shared types and constants of the top-k largest tracker
// ----------------------------------------------------------------------------
package tklt_pkg;

  // number of ranks held and stored tag width
  localparam int unsigned DEPTH    = 15;
  localparam int unsigned TAG_BITS = 16;

  // fixed field widths of the beat payload
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned TAGF_W = 16;
  localparam int unsigned RIDX_W = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNTF_W = 4;

  // internal widths derived from the depth
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // one result beat
  typedef struct packed {
    logic              accepted;
    logic [POS_W-1:0]  position;
    logic              entry_valid;
    logic [TAGF_W-1:0] entry_tag;
    logic [SIZE_W-1:0] entry_size;
    logic [CNTF_W-1:0] entry_count;
  } res_t;

endpackage

/* design/tklt_cell.sv */
// ----------------------------------------------------------------------------
// tklt_cell
// one rank of the insertion chain: keeps, loads the offer, or takes its
// upper neighbor's entry
// ----------------------------------------------------------------------------
module tklt_cell (
  input  logic                           clk_i,
  input  logic                           take_i,
  input  logic                           occupied_i,
  input  logic [tklt_pkg::SIZE_W-1:0]    item_size_i,
  input  logic [tklt_pkg::TAG_BITS-1:0]  item_tag_i,
  input  logic                           prev_ge_i,
  input  logic [tklt_pkg::SIZE_W-1:0]    prev_size_i,
  input  logic [tklt_pkg::TAG_BITS-1:0]  prev_tag_i,
  output logic                           ge_o,
  output logic                           ins_o,
  output logic [tklt_pkg::SIZE_W-1:0]    size_o,
  output logic [tklt_pkg::TAG_BITS-1:0]  tag_o
);
  import tklt_pkg::*;

  logic [SIZE_W-1:0]   size_q, size_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // entry stays in place when it is at least as large as the offer
  assign ge_o  = occupied_i && (size_q >= item_size_i);
  assign ins_o = !ge_o && prev_ge_i;

  always_comb begin
    size_d = size_q;
    tag_d  = tag_q;
    if (take_i && !ge_o) begin
      if (prev_ge_i) begin
        size_d = item_size_i;
        tag_d  = item_tag_i;
      end else begin
        size_d = prev_size_i;
        tag_d  = prev_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    tag_q  <= tag_d;
  end

  assign size_o = size_q;
  assign tag_o  = tag_q;

endmodule

/* design/tklt_out_stage.sv */
// ----------------------------------------------------------------------------
// tklt_out_stage
// output register with a skid slot, so a new beat is taken while a result
// waits downstream
// ----------------------------------------------------------------------------
module tklt_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tklt_pkg::res_t  res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tklt_pkg::res_t  res_o
);
  import tklt_pkg::*;

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic main_free;

  assign main_free = !main_valid_q || !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign res_o       = main_q;

endmodule

/* design/top_k_largest_tracker_unit.sv */
// ----------------------------------------------------------------------------
// top_k_largest_tracker_unit
// keeps the DEPTH largest offered items in descending size order
// ----------------------------------------------------------------------------
// Each input beat is one action: clear, offer or read. Its result beat is
// registered in the output register, or in the skid slot under a stall.
// One beat per cycle is sustained unless in_stall_o is high; that figure
// is set by the row of rank cells, which all compare against the offer and
// shift by one rank in the same cycle. Offers land below every entry of
// equal or larger size; once the list is full an offer must be strictly
// larger than the last rank to get in, and the last rank then drops out.
// Reads at or past the count return zeros with entry_valid low. Action
// code 3 changes nothing. The rank storage has no reset and needs no
// clearing pass: only ranks below the count are ever observed. A two-deep
// output stage lets the input keep moving while a result waits.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tklt_pkg::ACT_W-1:0]    action_i,
  input  logic [tklt_pkg::SIZE_W-1:0]   item_size_i,
  input  logic [tklt_pkg::TAGF_W-1:0]   item_tag_i,
  input  logic [tklt_pkg::RIDX_W-1:0]   read_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [tklt_pkg::POS_W-1:0]    insert_position_o,
  output logic                          entry_valid_o,
  output logic [tklt_pkg::TAGF_W-1:0]   entry_tag_o,
  output logic [tklt_pkg::SIZE_W-1:0]   entry_size_o,
  output logic [tklt_pkg::CNTF_W-1:0]   entry_count_o
);
  import tklt_pkg::*;

  // handshake
  logic    stage_full;
  logic    in_fire;
  action_e act;

  assign in_stall_o = stage_full;
  assign in_fire    = in_valid_i && !stage_full;
  assign act        = action_e'(action_i);

  // held entry count
  logic [CNT_W-1:0] count_q, count_d;

  // offer as stored in the cells
  logic [TAG_BITS-1:0] item_tag;
  assign item_tag = TAG_BITS'(item_tag_i);

  // cell row wiring
  logic [SIZE_W-1:0]   cell_size [DEPTH];
  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  logic [SIZE_W-1:0]   prev_size [DEPTH];
  logic [TAG_BITS-1:0] prev_tag  [DEPTH];
  logic [DEPTH-1:0]    cell_ge;
  logic [DEPTH-1:0]    prev_ge;
  logic [DEPTH-1:0]    cell_ins;
  logic                offer_fire;
  logic                take;

  assign offer_fire = in_fire && (act == ACT_OFFER);
  // some rank sits at the insertion point exactly when the offer gets in
  assign take       = |cell_ins;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    // rank 0 has nothing above it, so it sees a permanent stay flag
    if (gi == 0) begin : g_head
      assign prev_ge[gi]   = 1'b1;
      assign prev_size[gi] = item_size_i;
      assign prev_tag[gi]  = item_tag;
    end else begin : g_body
      assign prev_ge[gi]   = cell_ge[gi-1];
      assign prev_size[gi] = cell_size[gi-1];
      assign prev_tag[gi]  = cell_tag[gi-1];
    end

    tklt_cell u_cell (
      .clk_i       (clk_i),
      .take_i      (offer_fire),
      .occupied_i  (CNT_W'(gi) < count_q),
      .item_size_i (item_size_i),
      .item_tag_i  (item_tag),
      .prev_ge_i   (prev_ge[gi]),
      .prev_size_i (prev_size[gi]),
      .prev_tag_i  (prev_tag[gi]),
      .ge_o        (cell_ge[gi]),
      .ins_o       (cell_ins[gi]),
      .size_o      (cell_size[gi]),
      .tag_o       (cell_tag[gi])
    );
  end

  // encode the one-hot insertion point into a rank
  logic [IDX_W-1:0] ins_pos;
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_ins[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  // read port over the cell row
  logic [CMP_W-1:0] rd_idx;
  logic             rd_hit;
  assign rd_idx = CMP_W'(read_index_i);
  assign rd_hit = rd_idx < CMP_W'(count_q);

  // count update and result assembly
  res_t res;
  always_comb begin
    count_d = count_q;
    res     = '0;
    case (act)
      ACT_CLEAR: begin
        count_d = '0;
      end
      ACT_OFFER: begin
        if (take) begin
          res.accepted = 1'b1;
          res.position = POS_W'(ins_pos);
          // a full list drops its last rank, so the count holds
          if (count_q < CNT_W'(DEPTH)) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ACT_READ: begin
        if (rd_hit) begin
          res.entry_valid = 1'b1;
          res.entry_tag   = TAGF_W'(cell_tag[rd_idx[IDX_W-1:0]]);
          res.entry_size  = cell_size[rd_idx[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    res.entry_count = CNTF_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // output register and skid slot
  res_t res_out;
  tklt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .res_i       (res),
    .full_o      (stage_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign accepted_o        = res_out.accepted;
  assign insert_position_o = res_out.position;
  assign entry_valid_o     = res_out.entry_valid;
  assign entry_tag_o       = res_out.entry_tag;
  assign entry_size_o      = res_out.entry_size;
  assign entry_count_o     = res_out.entry_count;

`ifndef NO_ASSERTIONS
  // the count never passes the number of ranks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // at most one rank is the insertion point
  a_ins_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_ins))
    else $error("more than one insertion point");

  // an accepted offer leaves at least one entry held
  a_take_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (offer_fire && take) |=> (count_q != '0))
    else $error("accepted offer left an empty list");

  // a beat in the skid slot implies a beat in the output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_full |-> out_valid_o)
    else $error("skid slot filled ahead of output register");
`endif

endmodule

/* tb/tb_top_k_largest_tracker_unit.sv */
// ----------------------------------------------------------------------------
// tb_top_k_largest_tracker_unit
// self-checking bench for the top-k largest tracker
// ----------------------------------------------------------------------------
// Each beat applied to the block is also applied to a behavioral copy of the
// ranked list kept here. That copy gives the result beat due for the beat.
// The beats cover clear, offer and read, the unused action code, ties,
// eviction from a full list and reads past the count. The result checker
// takes every result beat in order and compares it field by field with the
// oldest prediction. The sender idles in random bursts and gaps. The result
// side stalls in its own changing patterns. A watchdog ends the run if no
// beat moves for too long.
// ----------------------------------------------------------------------------
module tb_top_k_largest_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tklt_pkg::*;

  // action code 3 is not part of the package enum: it only reports the count
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  // cycles without any beat moving before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // settle time after the last result, the block has a short output pipe
  localparam int unsigned TAIL_CYCLES = 8;

  // key styles for offered sizes
  typedef enum int unsigned {
    KEY_CROWDED,  // tiny range, lots of equal sizes
    KEY_TOP,      // near all-ones, ties at the top of the range
    KEY_ONEHOT,   // a single bit set, walks every bit of the size field
    KEY_FULL      // anything in 32 bits
  } key_style_e;

  // result-side stall patterns
  typedef enum int unsigned {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_stall_o;
  logic [ACT_W-1:0]    action_i          = ACT_CLEAR;
  logic [SIZE_W-1:0]   item_size_i       = '0;
  logic [TAGF_W-1:0]   item_tag_i        = '0;
  logic [RIDX_W-1:0]   read_index_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i       = 1'b0;
  logic                accepted_o;
  logic [POS_W-1:0]    insert_position_o;
  logic                entry_valid_o;
  logic [TAGF_W-1:0]   entry_tag_o;
  logic [SIZE_W-1:0]   entry_size_o;
  logic [CNTF_W-1:0]   entry_count_o;

  top_k_largest_tracker_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // behavioral ranked list: kept_sizes[0] is the largest entry
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]   kept_sizes [DEPTH];
  logic [TAG_BITS-1:0] kept_tags  [DEPTH];
  int unsigned         kept_count = 0;

  // result beats still owed by the block, oldest first
  res_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;

  // apply one action to the list and return the result beat it should give
  function automatic res_t apply_action(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] size,
                                        logic [TAGF_W-1:0] tag, logic [RIDX_W-1:0] ridx);
    res_t        r;
    int unsigned slot;
    bit          take;
    r    = '0;
    slot = 0;
    take = 1'b0;
    case (act)
      ACT_CLEAR: kept_count = 0;
      ACT_OFFER: begin
        // room left: always taken; full: must beat the last rank strictly
        if (kept_count < DEPTH) begin
          slot = kept_count;
          kept_count++;
          take = 1'b1;
        end else begin
          slot = DEPTH - 1;
          take = size > kept_sizes[DEPTH-1];
        end
        if (take) begin
          // slide smaller entries down, stop under any equal or larger one
          while (slot > 0 && kept_sizes[slot-1] < size) begin
            kept_sizes[slot] = kept_sizes[slot-1];
            kept_tags[slot]  = kept_tags[slot-1];
            slot--;
          end
          kept_sizes[slot] = size;
          kept_tags[slot]  = tag[TAG_BITS-1:0];
          r.accepted = 1'b1;
          r.position = slot[POS_W-1:0];
        end
      end
      ACT_READ: begin
        if (ridx < kept_count) begin
          r.entry_valid = 1'b1;
          r.entry_tag   = TAGF_W'(kept_tags[ridx]);
          r.entry_size  = kept_sizes[ridx];
        end
      end
      default: ;
    endcase
    r.entry_count = kept_count[CNTF_W-1:0];
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(key_style_e style);
    case (style)
      KEY_CROWDED: return SIZE_W'($urandom_range(0, 15));
      KEY_TOP:     return '1 - SIZE_W'($urandom_range(0, 15));
      KEY_ONEHOT:  return SIZE_W'(1) << $urandom_range(0, SIZE_W - 1);
      default:     return $urandom();
    endcase
  endfunction

  function automatic logic [TAGF_W-1:0] pick_tag();
    return TAGF_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input beat driver
  // valid stays high from one beat to the next inside a burst; it is only
  // lowered for a gap or a pause, in a step where it is not raised again
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] size,
                           logic [TAGF_W-1:0] tag, logic [RIDX_W-1:0] ridx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      // a quarter of the bursts follow the previous one back to back
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    item_size_i  <= size;
    item_tag_i   <= tag;
    read_index_i <= ridx;
    // the beat moves at the first edge that sees stall low
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_action(act, size, tag, ridx));
  endtask

  // stop sending and wait until every owed result beat has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result checker: outputs are sampled at the edge, before the block updates
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t seen;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.accepted    = accepted_o;
      seen.position    = insert_position_o;
      seen.entry_valid = entry_valid_o;
      seen.entry_tag   = entry_tag_o;
      seen.entry_size  = entry_size_o;
      seen.entry_count = entry_count_o;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing owed", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (seen.accepted !== want.accepted)
          report_mismatch("accepted", 32'(seen.accepted), 32'(want.accepted));
        if (seen.position !== want.position)
          report_mismatch("insert_position", 32'(seen.position), 32'(want.position));
        if (seen.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", 32'(seen.entry_valid), 32'(want.entry_valid));
        if (seen.entry_tag !== want.entry_tag)
          report_mismatch("entry_tag", 32'(seen.entry_tag), 32'(want.entry_tag));
        if (seen.entry_size !== want.entry_size)
          report_mismatch("entry_size", seen.entry_size, want.entry_size);
        if (seen.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(seen.entry_count), 32'(want.entry_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result-side stall: a mode held for a random stretch, then another one
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_FLOW;
  int unsigned rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 64);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= ~out_stall_i;
    endcase
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat on either side for too long means a hang
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[top_k_largest_tracker_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, ties, the unused code, out-of-range reads and eviction
  task automatic test_directed();
    int unsigned i;
    send_beat(ACT_READ, '0, '0, 4'd0);               // empty list, nothing valid
    send_beat(ACT_NOP, '1, '1, 4'd14);               // unused code changes nothing
    send_beat(ACT_OFFER, '0, '0, 4'd0);              // smallest size, lands at rank 0
    send_beat(ACT_OFFER, '1, '1, 4'd0);              // largest size jumps to the top
    send_beat(ACT_OFFER, '0, 16'h1234, 4'd0);        // tie stays behind the older zero
    send_beat(ACT_READ, '0, '0, 4'd2);
    send_beat(ACT_READ, '0, '0, 4'd3);               // just past the count
    // fill to the top with distinct middling sizes
    for (i = 0; i < DEPTH - 3; i++)
      send_beat(ACT_OFFER, SIZE_W'(16 + i), TAGF_W'(16'hA000 + i), '0);
    send_beat(ACT_OFFER, '0, 16'h5555, 4'd0);        // full, equal to last: rejected
    send_beat(ACT_OFFER, SIZE_W'(1), 16'hAAAA, 4'd0);// full, larger: last drops out
    send_beat(ACT_OFFER, '1, 16'h0F0F, 4'd0);        // ties the top entry
    send_beat(ACT_READ, '0, '0, 4'd14);              // last rank of a full list
    send_beat(ACT_READ, '0, '0, 4'd1);
    send_beat(ACT_CLEAR, '1, '1, 4'd7);
    send_beat(ACT_READ, '0, '0, 4'd0);               // cleared list reads empty
  endtask

  // well-formed rounds: clear, then mostly offers with reads in between
  task automatic test_ranked_rounds();
    int unsigned round;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    key_style_e  style;
    for (round = 0; round < 24; round++) begin
      style = key_style_e'(round % 4);
      send_beat(ACT_CLEAR, pick_size(style), pick_tag(), RIDX_W'($urandom_range(0, 14)));
      n = $urandom_range(10, 70);
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 68)
          send_beat(ACT_OFFER, pick_size(style), pick_tag(), RIDX_W'($urandom_range(0, 14)));
        else if (pick < 94)
          send_beat(ACT_READ, pick_size(style), pick_tag(), RIDX_W'($urandom_range(0, 14)));
        else if (pick < 98)
          send_beat(ACT_NOP, pick_size(style), pick_tag(), RIDX_W'($urandom_range(0, 14)));
        else
          send_beat(ACT_CLEAR, pick_size(style), pick_tag(), RIDX_W'($urandom_range(0, 14)));
      end
    end
  endtask

  // the sender holds off until the block has nothing left to return
  task automatic test_drain_pause();
    int unsigned k;
    int unsigned phase;
    for (phase = 0; phase < 3; phase++) begin
      for (k = 0; k < 20; k++)
        send_beat(($urandom_range(0, 2) == 0) ? ACT_READ : ACT_OFFER,
                  pick_size(KEY_FULL), pick_tag(), RIDX_W'($urandom_range(0, 14)));
      drain_results();
    end
  endtask

  // loose mix of every action with any field values
  task automatic test_random_mix();
    int unsigned k;
    int unsigned pick;
    logic [ACT_W-1:0] act;
    for (k = 0; k < 250; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       act = ACT_CLEAR;
      else if (pick < 55) act = ACT_OFFER;
      else if (pick < 90) act = ACT_READ;
      else                act = ACT_NOP;
      send_beat(act, pick_size(key_style_e'($urandom_range(0, 3))), pick_tag(),
                RIDX_W'($urandom_range(0, 14)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_drain_pause();
    test_ranked_rounds();
    test_random_mix();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[top_k_largest_tracker_unit] OK");
    else
      $display("[top_k_largest_tracker_unit] ERROR");
    $finish;
  end

endmodule

/* top_k_largest_tracker_unit.f */
design/tklt_pkg.sv
design/tklt_cell.sv
design/tklt_out_stage.sv
design/top_k_largest_tracker_unit.sv
tb/tb_top_k_largest_tracker_unit.sv
